// File: hdl/scsd_pkg.sv
// shared types and constants for the stereo clap sync detector
// no dependencies; used by every module in hdl except scsd_window
package scsd_pkg;

    // field widths fixed by the interface
    localparam int COORD_IN_W = 11;
    localparam int THR_W      = 12;
    localparam int LIM_W      = 6;
    localparam int APEX_W     = 5;
    localparam int OFFSET_W   = 6;
    localparam int ACCEL_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LIM = 1'b1;

    // register reset values
    localparam logic [THR_W-1:0]        THR_RESET = 12'd400;
    localparam logic signed [LIM_W-1:0] LIM_RESET = 6'sd4;

    // input word kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REARM  = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SRCH_R = 7'b0000010,
        ST_EVAL_R = 7'b0000100,
        ST_SRCH_L = 7'b0001000,
        ST_EVAL_L = 7'b0010000,
        ST_DROP   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    // control from the sequencer to the shared unit and peak tracker
    typedef struct packed {
        logic clear;
        logic step;
    } srch_ctrl_t;

endpackage

// File: hdl/scsd_window.sv
// sliding window of marker centres held as a rotating shift line
// depends on nothing beyond its parameters; taps give entries 0, 1 and 2
module scsd_window #(
    parameter int WINDOW_LEN = 20,
    parameter int COORD_BITS = 11
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(WINDOW_LEN)-1:0] wr_idx,
    input  logic [2*COORD_BITS-1:0]       wr_data,
    input  logic                          rot_en,
    output logic [2*COORD_BITS-1:0]       tap0,
    output logic [2*COORD_BITS-1:0]       tap1,
    output logic [2*COORD_BITS-1:0]       tap2
);

    logic [2*COORD_BITS-1:0] entry_reg [WINDOW_LEN];

    // rotate towards entry 0; the old head wraps to the tail
    always_ff @(posedge aclk) begin
        if (rot_en) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                entry_reg[k] <= entry_reg[(k + 1) % WINDOW_LEN];
            end
        end else if (wr_en) begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    assign tap0 = entry_reg[0];
    assign tap1 = entry_reg[1];
    assign tap2 = entry_reg[2];

endmodule

// File: hdl/scsd_accel_unit.sv
// shared second difference and squared magnitude unit, one triple a cycle
// depends on scsd_pkg for the control struct; output stage is registered
module scsd_accel_unit #(
    parameter int WINDOW_LEN = 20,
    parameter int COORD_BITS = 11
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  scsd_pkg::srch_ctrl_t            ctrl,
    input  logic [2*COORD_BITS-1:0]         tap_a,
    input  logic [2*COORD_BITS-1:0]         tap_b,
    input  logic [2*COORD_BITS-1:0]         tap_c,
    input  logic [$clog2(WINDOW_LEN)-1:0]   idx_in,
    output logic                            o_valid,
    output logic                            o_zero,
    output logic signed [COORD_BITS+1:0]    o_dx,
    output logic signed [COORD_BITS+1:0]    o_dy,
    output logic [2*COORD_BITS+3:0]         o_mag,
    output logic [$clog2(WINDOW_LEN)-1:0]   o_idx
);

    localparam int C   = COORD_BITS;
    localparam int D_W = COORD_BITS + 2;
    localparam int M_W = 2 * D_W;
    localparam int I_W = $clog2(WINDOW_LEN);

    logic [C-1:0] ax, ay, bx, by, cx, cy;
    logic signed [D_W-1:0] dx_c, dy_c;
    logic signed [M_W-1:0] sqx_c, sqy_c;
    logic [M_W-1:0] mag_c;
    logic zero_c;

    logic v_reg, zero_reg;
    logic signed [D_W-1:0] dx_reg, dy_reg;
    logic [M_W-1:0] mag_reg;
    logic [I_W-1:0] idx_reg;

    assign {ax, ay} = tap_a;
    assign {bx, by} = tap_b;
    assign {cx, cy} = tap_c;

    assign dx_c = $signed({2'b00, cx}) + $signed({2'b00, ax}) - $signed({1'b0, bx, 1'b0});
    assign dy_c = $signed({2'b00, cy}) + $signed({2'b00, ay}) - $signed({1'b0, by, 1'b0});

    assign sqx_c = M_W'(dx_c) * M_W'(dx_c);
    assign sqy_c = M_W'(dy_c) * M_W'(dy_c);
    assign mag_c = M_W'($unsigned(sqx_c)) + M_W'($unsigned(sqy_c));

    // an absent marker anywhere in the triple spoils the whole window
    assign zero_c = (tap_a == '0) || (tap_b == '0) || (tap_c == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= ctrl.step & ~ctrl.clear;
        end
    end

    always_ff @(posedge aclk) begin
        zero_reg <= zero_c;
        dx_reg   <= dx_c;
        dy_reg   <= dy_c;
        mag_reg  <= mag_c;
        idx_reg  <= idx_in;
    end

    assign o_valid = v_reg;
    assign o_zero  = zero_reg;
    assign o_dx    = dx_reg;
    assign o_dy    = dy_reg;
    assign o_mag   = mag_reg;
    assign o_idx   = idx_reg;

endmodule

// File: hdl/scsd_peak_track.sv
// running maximum of squared magnitude over one window walk
// depends on scsd_pkg for the control struct; fed by scsd_accel_unit
module scsd_peak_track #(
    parameter int WINDOW_LEN = 20,
    parameter int COORD_BITS = 11
) (
    input  logic                            aclk,
    input  scsd_pkg::srch_ctrl_t            ctrl,
    input  logic                            s_valid_step,
    input  logic                            s_zero,
    input  logic signed [COORD_BITS+1:0]    s_dx,
    input  logic signed [COORD_BITS+1:0]    s_dy,
    input  logic [2*COORD_BITS+3:0]         s_mag,
    input  logic [$clog2(WINDOW_LEN)-1:0]   s_idx,
    output logic [$clog2(WINDOW_LEN)-1:0]   pk_idx,
    output logic signed [COORD_BITS+1:0]    pk_ax,
    output logic signed [COORD_BITS+1:0]    pk_ay
);

    localparam int D_W = COORD_BITS + 2;
    localparam int M_W = 2 * D_W;
    localparam int I_W = $clog2(WINDOW_LEN);

    logic [M_W-1:0] best_reg;
    logic [I_W-1:0] bidx_reg;
    logic signed [D_W-1:0] bax_reg, bay_reg;
    logic inval_reg;

    // first strictly larger magnitude wins, so ties keep the earlier index
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            best_reg  <= M_W'(1);
            bidx_reg  <= '0;
            bax_reg   <= '0;
            bay_reg   <= '0;
            inval_reg <= 1'b0;
        end else if (s_valid_step) begin
            if (s_zero) begin
                inval_reg <= 1'b1;
            end
            if (s_mag > best_reg) begin
                best_reg <= s_mag;
                bidx_reg <= s_idx;
                bax_reg  <= s_dx;
                bay_reg  <= s_dy;
            end
        end
    end

    assign pk_idx = inval_reg ? '0 : bidx_reg;
    assign pk_ax  = inval_reg ? '0 : bax_reg;
    assign pk_ay  = inval_reg ? '0 : bay_reg;

endmodule

// File: hdl/stereo_clap_sync_detector_unit.sv
// stereo clap sync detector: two sliding windows, one shared accel unit
// rearm, synced and filling words go straight to the result stage; a word that fills the
// window walks the right window, and the left one only after a valid right peak over threshold;
// each walk rotates its window full circle; the next word is taken in the cycle after the
// result is loaded, and a result held by the receiver holds the input too
// reset: windows undefined, fill count 0, armed, thresholds 400 and 4, output empty
module stereo_clap_sync_detector_unit #(
    parameter int WINDOW_LEN = 20,
    parameter int COORD_BITS = 11
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [scsd_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input words
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_kind,
    input  logic [scsd_pkg::COORD_IN_W-1:0]       s_right_x,
    input  logic [scsd_pkg::COORD_IN_W-1:0]       s_right_y,
    input  logic [scsd_pkg::COORD_IN_W-1:0]       s_left_x,
    input  logic [scsd_pkg::COORD_IN_W-1:0]       s_left_y,
    // result words
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_synced,
    output logic                                  m_clap_detected,
    output logic signed [scsd_pkg::OFFSET_W-1:0]  m_match_offset,
    output logic [scsd_pkg::APEX_W-1:0]           m_apex_right,
    output logic [scsd_pkg::APEX_W-1:0]           m_apex_left,
    output logic signed [scsd_pkg::ACCEL_W-1:0]   m_peak_accel_x,
    output logic signed [scsd_pkg::ACCEL_W-1:0]   m_peak_accel_y
);

    localparam int C     = COORD_BITS;
    localparam int D_W   = COORD_BITS + 2;
    localparam int M_W   = 2 * D_W;
    localparam int I_W   = $clog2(WINDOW_LEN);
    localparam int CX_W  = (C > scsd_pkg::COORD_IN_W) ? C : scsd_pkg::COORD_IN_W;
    localparam int CMP_W = (D_W > scsd_pkg::THR_W) ? D_W : scsd_pkg::THR_W;
    localparam int AX_W  = (D_W > scsd_pkg::ACCEL_W) ? D_W : scsd_pkg::ACCEL_W;
    localparam int OFF_W = scsd_pkg::APEX_W + 2;

    localparam logic [I_W-1:0] ROT_LAST  = I_W'(WINDOW_LEN - 1);
    localparam logic [I_W-1:0] STEP_LAST = I_W'(WINDOW_LEN - 3);
    localparam logic [I_W-1:0] FILL_LAST = I_W'(WINDOW_LEN - 1);

    // sequencer and control state
    scsd_pkg::state_t state_reg, state_next;
    logic [I_W-1:0] rot_reg, rot_next;
    logic [I_W-1:0] fill_reg, fill_next;
    logic sync_reg, sync_next;
    logic m_valid_reg, m_valid_next;

    // configuration registers
    logic [scsd_pkg::THR_W-1:0] thr_reg;
    logic signed [scsd_pkg::LIM_W-1:0] lim_reg;

    // result being built for the current word
    logic res_synced_reg, res_synced_next;
    logic res_clap_reg, res_clap_next;
    logic signed [OFF_W-1:0] res_off_reg, res_off_next;
    logic [I_W-1:0] res_apex_r_reg, res_apex_r_next;
    logic [I_W-1:0] res_apex_l_reg, res_apex_l_next;
    logic signed [D_W-1:0] res_pax_reg, res_pax_next;
    logic signed [D_W-1:0] res_pay_reg, res_pay_next;

    // output register, parts the result side from the sequencer
    logic m_synced_reg, m_synced_next;
    logic m_clap_reg, m_clap_next;
    logic signed [scsd_pkg::OFFSET_W-1:0] m_off_reg, m_off_next;
    logic [scsd_pkg::APEX_W-1:0] m_apex_r_reg, m_apex_r_next;
    logic [scsd_pkg::APEX_W-1:0] m_apex_l_reg, m_apex_l_next;
    logic signed [scsd_pkg::ACCEL_W-1:0] m_pax_reg, m_pax_next;
    logic signed [scsd_pkg::ACCEL_W-1:0] m_pay_reg, m_pay_next;

    // window and shared unit wiring
    logic [CX_W-1:0] rx_ext, ry_ext, lx_ext, ly_ext;
    logic [2*C-1:0] r_wr_data, l_wr_data;
    logic wr_en, rot_r, rot_l, sel_left;
    logic [2*C-1:0] r_tap0, r_tap1, r_tap2, l_tap0, l_tap1, l_tap2;
    logic [2*C-1:0] u_tap0, u_tap1, u_tap2;
    scsd_pkg::srch_ctrl_t ctrl;

    logic u_valid, u_zero;
    logic signed [D_W-1:0] u_dx, u_dy;
    logic [M_W-1:0] u_mag;
    logic [I_W-1:0] u_idx;
    logic [I_W-1:0] pk_idx;
    logic signed [D_W-1:0] pk_ax, pk_ay;

    logic [D_W-1:0] abs_x, abs_y;
    logic over_thr;
    logic signed [OFF_W-1:0] off_c, lim_c;
    logic signed [AX_W-1:0] pax_ext, pay_ext;

    // only the low coordinate bits are kept, zero padded if wider
    assign rx_ext    = CX_W'(s_right_x);
    assign ry_ext    = CX_W'(s_right_y);
    assign lx_ext    = CX_W'(s_left_x);
    assign ly_ext    = CX_W'(s_left_y);
    assign r_wr_data = {rx_ext[C-1:0], ry_ext[C-1:0]};
    assign l_wr_data = {lx_ext[C-1:0], ly_ext[C-1:0]};

    scsd_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .COORD_BITS (COORD_BITS)
    ) u_win_right (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (fill_reg),
        .wr_data (r_wr_data),
        .rot_en  (rot_r),
        .tap0    (r_tap0),
        .tap1    (r_tap1),
        .tap2    (r_tap2)
    );

    scsd_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .COORD_BITS (COORD_BITS)
    ) u_win_left (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (fill_reg),
        .wr_data (l_wr_data),
        .rot_en  (rot_l),
        .tap0    (l_tap0),
        .tap1    (l_tap1),
        .tap2    (l_tap2)
    );

    // one accel unit serves both windows in turn
    assign u_tap0 = sel_left ? l_tap0 : r_tap0;
    assign u_tap1 = sel_left ? l_tap1 : r_tap1;
    assign u_tap2 = sel_left ? l_tap2 : r_tap2;

    scsd_accel_unit #(
        .WINDOW_LEN (WINDOW_LEN),
        .COORD_BITS (COORD_BITS)
    ) u_accel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .tap_a   (u_tap0),
        .tap_b   (u_tap1),
        .tap_c   (u_tap2),
        .idx_in  (I_W'(rot_reg + I_W'(2))),
        .o_valid (u_valid),
        .o_zero  (u_zero),
        .o_dx    (u_dx),
        .o_dy    (u_dy),
        .o_mag   (u_mag),
        .o_idx   (u_idx)
    );

    scsd_peak_track #(
        .WINDOW_LEN (WINDOW_LEN),
        .COORD_BITS (COORD_BITS)
    ) u_track (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .s_valid_step (u_valid),
        .s_zero       (u_zero),
        .s_dx         (u_dx),
        .s_dy         (u_dy),
        .s_mag        (u_mag),
        .s_idx        (u_idx),
        .pk_idx       (pk_idx),
        .pk_ax        (pk_ax),
        .pk_ay        (pk_ay)
    );

    // per-axis threshold test on the right peak
    assign abs_x    = pk_ax[D_W-1] ? $unsigned(-pk_ax) : $unsigned(pk_ax);
    assign abs_y    = pk_ay[D_W-1] ? $unsigned(-pk_ay) : $unsigned(pk_ay);
    assign over_thr = (CMP_W'(abs_x) > CMP_W'(thr_reg)) || (CMP_W'(abs_y) > CMP_W'(thr_reg));

    // signed offset left minus right, compared at full precision
    assign off_c = $signed({2'b00, scsd_pkg::APEX_W'(pk_idx)})
                 - $signed({2'b00, scsd_pkg::APEX_W'(res_apex_r_reg)});
    assign lim_c = OFF_W'(lim_reg);

    assign pax_ext = AX_W'(res_pax_reg);
    assign pay_ext = AX_W'(res_pay_reg);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        rot_next        = rot_reg;
        fill_next       = fill_reg;
        sync_next       = sync_reg;
        res_synced_next = res_synced_reg;
        res_clap_next   = res_clap_reg;
        res_off_next    = res_off_reg;
        res_apex_r_next = res_apex_r_reg;
        res_apex_l_next = res_apex_l_reg;
        res_pax_next    = res_pax_reg;
        res_pay_next    = res_pay_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_synced_next   = m_synced_reg;
        m_clap_next     = m_clap_reg;
        m_off_next      = m_off_reg;
        m_apex_r_next   = m_apex_r_reg;
        m_apex_l_next   = m_apex_l_reg;
        m_pax_next      = m_pax_reg;
        m_pay_next      = m_pay_reg;
        wr_en           = 1'b0;
        rot_r           = 1'b0;
        rot_l           = 1'b0;
        sel_left        = 1'b0;
        ctrl.clear      = 1'b0;
        ctrl.step       = 1'b0;

        case (state_reg)
            scsd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    res_synced_next = 1'b0;
                    res_clap_next   = 1'b0;
                    res_off_next    = '0;
                    res_apex_r_next = '0;
                    res_apex_l_next = '0;
                    res_pax_next    = '0;
                    res_pay_next    = '0;
                    if (s_kind == scsd_pkg::KIND_REARM) begin
                        sync_next  = 1'b0;
                        fill_next  = '0;
                        state_next = scsd_pkg::ST_DONE;
                    end else if (sync_reg) begin
                        // samples are dropped while synced
                        res_synced_next = 1'b1;
                        state_next      = scsd_pkg::ST_DONE;
                    end else begin
                        wr_en = 1'b1;
                        if (fill_reg == FILL_LAST) begin
                            rot_next   = '0;
                            ctrl.clear = 1'b1;
                            state_next = scsd_pkg::ST_SRCH_R;
                        end else begin
                            fill_next  = I_W'(fill_reg + I_W'(1));
                            state_next = scsd_pkg::ST_DONE;
                        end
                    end
                end
            end
            scsd_pkg::ST_SRCH_R: begin
                rot_r     = 1'b1;
                ctrl.step = (rot_reg <= STEP_LAST);
                rot_next  = I_W'(rot_reg + I_W'(1));
                if (rot_reg == ROT_LAST) begin
                    rot_next   = '0;
                    state_next = scsd_pkg::ST_EVAL_R;
                end
            end
            scsd_pkg::ST_EVAL_R: begin
                res_apex_r_next = pk_idx;
                res_pax_next    = pk_ax;
                res_pay_next    = pk_ay;
                if ((pk_idx != '0) && over_thr) begin
                    ctrl.clear = 1'b1;
                    state_next = scsd_pkg::ST_SRCH_L;
                end else begin
                    state_next = scsd_pkg::ST_DROP;
                end
            end
            scsd_pkg::ST_SRCH_L: begin
                sel_left  = 1'b1;
                rot_l     = 1'b1;
                ctrl.step = (rot_reg <= STEP_LAST);
                rot_next  = I_W'(rot_reg + I_W'(1));
                if (rot_reg == ROT_LAST) begin
                    rot_next   = '0;
                    state_next = scsd_pkg::ST_EVAL_L;
                end
            end
            scsd_pkg::ST_EVAL_L: begin
                res_apex_l_next = pk_idx;
                state_next      = scsd_pkg::ST_DROP;
                if (pk_idx != '0) begin
                    res_off_next = off_c;
                    if (off_c < lim_c) begin
                        sync_next       = 1'b1;
                        fill_next       = '0;
                        res_synced_next = 1'b1;
                        res_clap_next   = 1'b1;
                        state_next      = scsd_pkg::ST_DONE;
                    end
                end
            end
            scsd_pkg::ST_DROP: begin
                // one more rotation drops the oldest entry; the tail is overwritten next
                rot_r      = 1'b1;
                rot_l      = 1'b1;
                state_next = scsd_pkg::ST_DONE;
            end
            scsd_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_synced_next = res_synced_reg;
                    m_clap_next   = res_clap_reg;
                    m_off_next    = res_off_reg[scsd_pkg::OFFSET_W-1:0];
                    m_apex_r_next = scsd_pkg::APEX_W'(res_apex_r_reg);
                    m_apex_l_next = scsd_pkg::APEX_W'(res_apex_l_reg);
                    m_pax_next    = pax_ext[scsd_pkg::ACCEL_W-1:0];
                    m_pay_next    = pay_ext[scsd_pkg::ACCEL_W-1:0];
                    state_next    = scsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scsd_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scsd_pkg::ST_IDLE;
            rot_reg     <= '0;
            fill_reg    <= '0;
            sync_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rot_reg     <= rot_next;
            fill_reg    <= fill_next;
            sync_reg    <= sync_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration registers, written whenever the channel offers a word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= scsd_pkg::THR_RESET;
            lim_reg <= scsd_pkg::LIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                scsd_pkg::REG_ACCEL_THR: begin
                    thr_reg <= cfg_data[scsd_pkg::THR_W-1:0];
                end
                scsd_pkg::REG_OFFSET_LIM: begin
                    lim_reg <= $signed(cfg_data[scsd_pkg::LIM_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        res_synced_reg <= res_synced_next;
        res_clap_reg   <= res_clap_next;
        res_off_reg    <= res_off_next;
        res_apex_r_reg <= res_apex_r_next;
        res_apex_l_reg <= res_apex_l_next;
        res_pax_reg    <= res_pax_next;
        res_pay_reg    <= res_pay_next;
        m_synced_reg   <= m_synced_next;
        m_clap_reg     <= m_clap_next;
        m_off_reg      <= m_off_next;
        m_apex_r_reg   <= m_apex_r_next;
        m_apex_l_reg   <= m_apex_l_next;
        m_pax_reg      <= m_pax_next;
        m_pay_reg      <= m_pay_next;
    end

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == scsd_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_synced        = m_synced_reg;
    assign m_clap_detected = m_clap_reg;
    assign m_match_offset  = m_off_reg;
    assign m_apex_right    = m_apex_r_reg;
    assign m_apex_left     = m_apex_l_reg;
    assign m_peak_accel_x  = m_pax_reg;
    assign m_peak_accel_y  = m_pay_reg;

    // a clap word always reports synced
    a_clap_synced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clap_detected |-> m_synced)
        else $error("clap reported without sync");

    // the left window is only walked after a right peak
    a_left_needs_right: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_apex_left != '0) |-> (m_apex_right != '0))
        else $error("left peak without right peak");

    // an accepted word makes the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // the fill count never reaches the window length
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_LAST)
        else $error("fill count out of range");

    // while synced the fill count stays at zero
    a_sync_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        sync_reg && (state_reg == scsd_pkg::ST_IDLE) |-> (fill_reg == '0))
        else $error("windows not empty while synced");

endmodule
